// ----- rtl/utf8_stream_decoder_macros.svh -----
// Assertion macros for the UTF-8 stream decoder.
// Included by the modules that assert; depends on nothing else.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("u8sd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("u8sd: next-cycle check failed");

`endif

// ----- rtl/u8sd_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by utf8_stream_decoder.
package u8sd_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ODATA_W = 24;

    localparam logic [BYTE_W-1:0] LEAD_MIN = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD_MAX = 8'hF4;
    localparam logic [BYTE_W-1:0] LEAD_E0  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_ED  = 8'hED;
    localparam logic [BYTE_W-1:0] LEAD_F0  = 8'hF0;

    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_3B  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4B  = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

    // Check applied to the finished value, chosen by the lead byte.
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_SURR  = 3'd1,
        KIND_OVER3 = 3'd2,
        KIND_OVER4 = 3'd3,
        KIND_MAX4  = 3'd4
    } t_check_kind;

endpackage

// ----- rtl/utf8_stream_decoder.sv -----
// UTF-8 stream decoder top level: input register, byte decode, result register.
// Depends on u8sd_pkg and utf8_stream_decoder_macros.svh.
//
//  channel   | dir | tdata                   | tlast          | tuser
//  ----------+-----+-------------------------+----------------+----------------
//  s_axis    | in  | [7:0] byte_in           | end_of_stream  | -
//  m_axis    | out | [20:0] code_point, pad  | -              | [0] valid_res
//
// One byte beat is taken every cycle unless a stall on m_axis holds a full input
// register. A byte waits in the input register and its result, if any, is
// loaded into the result register when the decode advances; the single decode step sets the rate.
// Reset (synchronous, active low) clears both valid flags and all sequence state.
// A stall on m_axis holds the result register and the byte behind it, so
// s_axis_tready falls as soon as the input register is full.
module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] byte_in
    input  logic                s_axis_tlast,   // end_of_stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [ODATA_W-1:0]  m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic                m_axis_tuser    // [0] valid_res
);

`include "utf8_stream_decoder_macros.svh"

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Sequence state.
    logic [1:0]        r_pending, n_pending;
    logic [CP_W-1:0]   r_acc, n_acc;
    t_check_kind       r_kind, n_kind;
    logic              r_bad, n_bad;
    logic              r_skip, n_skip;

    // Result register.
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_ok;

    // Decode outputs.
    logic              w_emit;
    logic [CP_W-1:0]   w_cp;
    logic              w_ok;
    logic              w_seq_ok;
    logic [CP_W-1:0]   w_acc_step;
    logic              w_bad_step;
    logic [1:0]        w_pend_step;

    logic w_advance;

    // The byte in the input register is decoded whenever the result register
    // can take a result, so state and result always advance together.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_comb begin
        w_bad_step  = r_bad;
        w_acc_step  = r_acc;
        w_pend_step = r_pending - 2'd1;
        if (r_in_byte[7:6] != 2'b10) begin
            w_bad_step = 1'b1;
        end else if (!r_bad) begin
            w_acc_step = {r_acc[CP_W-7:0], r_in_byte[5:0]};
        end

        // The finished value is checked after the last byte is folded in.
        w_seq_ok = 1'b1;
        if (w_bad_step) begin
            w_seq_ok = 1'b0;
        end else begin
            case (r_kind)
                KIND_SURR:  w_seq_ok = !(w_acc_step >= SURR_LO && w_acc_step <= SURR_HI);
                KIND_OVER3: w_seq_ok = (w_acc_step >= MIN_3B);
                KIND_OVER4: w_seq_ok = (w_acc_step >= MIN_4B);
                KIND_MAX4:  w_seq_ok = (w_acc_step <= CP_MAX);
                default:    w_seq_ok = 1'b1;
            endcase
        end
    end

    always_comb begin
        n_pending = r_pending;
        n_acc     = r_acc;
        n_kind    = r_kind;
        n_bad     = r_bad;
        n_skip    = r_skip;
        w_emit    = 1'b0;
        w_cp      = '0;
        w_ok      = 1'b0;

        if (r_pending != 2'd0) begin
            n_bad     = w_bad_step;
            n_acc     = w_acc_step;
            n_pending = w_pend_step;
            if (w_pend_step == 2'd0) begin
                w_emit = 1'b1;
                w_ok   = w_seq_ok;
                w_cp   = w_seq_ok ? w_acc_step : '0;
                n_acc  = '0;
                n_kind = KIND_NONE;
                n_bad  = 1'b0;
            end else if (r_in_last) begin
                // Sequence cut off by the end of the stream.
                w_emit = 1'b1;
            end
        end else if (r_skip && r_in_byte[7]) begin
            // Dropping high bytes after an invalid lead.
        end else begin
            n_skip = 1'b0;
            if (!r_in_byte[7]) begin
                w_emit = 1'b1;
                w_ok   = 1'b1;
                w_cp   = CP_W'(r_in_byte);
            end else if (r_in_byte < LEAD_MIN || r_in_byte > LEAD_MAX) begin
                w_emit = 1'b1;
                n_skip = 1'b1;
            end else begin
                n_bad = 1'b0;
                if (r_in_byte >= LEAD_F0) begin
                    n_pending = 2'd3;
                    n_acc     = CP_W'(r_in_byte[2:0]);
                    n_kind    = (r_in_byte == LEAD_F0) ? KIND_OVER4 : KIND_MAX4;
                end else if (r_in_byte >= LEAD_E0) begin
                    n_pending = 2'd2;
                    n_acc     = CP_W'(r_in_byte[3:0]);
                    n_kind    = (r_in_byte == LEAD_E0) ? KIND_OVER3 :
                                (r_in_byte == LEAD_ED) ? KIND_SURR : KIND_NONE;
                end else begin
                    n_pending = 2'd1;
                    n_acc     = CP_W'(r_in_byte[4:0]);
                    n_kind    = KIND_NONE;
                end
                // A lead byte that is also the last byte is a cut-off sequence.
                if (r_in_last) begin
                    w_emit = 1'b1;
                end
            end
        end

        // The end mark returns everything to the reset state.
        if (r_in_last) begin
            n_pending = 2'd0;
            n_acc     = '0;
            n_kind    = KIND_NONE;
            n_bad     = 1'b0;
            n_skip    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= 2'd0;
            r_acc       <= '0;
            r_kind      <= KIND_NONE;
            r_bad       <= 1'b0;
            r_skip      <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= s_axis_tdata;
                r_in_last  <= s_axis_tlast;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_pending <= n_pending;
                r_acc     <= n_acc;
                r_kind    <= n_kind;
                r_bad     <= n_bad;
                r_skip    <= n_skip;
            end

            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
                r_out_cp    <= w_cp;
                r_out_ok    <= w_ok;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ODATA_W'(r_out_cp);
    assign m_axis_tuser  = r_out_ok;

    // An error result carries a zero code point.
    `U8SD_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, r_out_valid && !r_out_ok, r_out_cp == '0)
    // A decoded character is a Unicode scalar value.
    `U8SD_ASSERT_IMPL(a_scalar, i_clk, i_rst_n, r_out_valid && r_out_ok,
        r_out_cp <= CP_MAX && !(r_out_cp >= SURR_LO && r_out_cp <= SURR_HI))
    // Skipping high bytes and an open sequence never coexist.
    `U8SD_ASSERT_IMPL(a_skip_idle, i_clk, i_rst_n, r_pending != 2'd0, !r_skip)
    // The last beat of a stream leaves all sequence state cleared.
    `U8SD_ASSERT_NEXT(a_eos_clear, i_clk, i_rst_n, w_advance && r_in_last,
        r_pending == 2'd0 && !r_skip && !r_bad && r_acc == '0)

endmodule
